FILE: hw/rtl/lzwc_pkg.sv
`timescale 1ns / 1ps

package lzwc_pkg;

  // Width of the emitted code field and of one input byte.
  localparam int CW_W = 12;
  localparam int BYTE_W = 8;

  // Default dictionary size and the first code after the 256 root codes.
  localparam int NUM_CODES_DEF = 4096;
  localparam int FIRST_FREE = 257;

  // One input byte can cause at most three results; the output queue holds four.
  localparam int MAX_RES = 3;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [CW_W-1:0] code;
    logic            last;
    logic            eos;
  } res_t;

endpackage

FILE: hw/rtl/lzwc_child_mem.sv
`timescale 1ns / 1ps

// Child table: one write port and one read port with registered read data.
module lzwc_child_mem #(
  parameter int NUM_CODES = lzwc_pkg::NUM_CODES_DEF
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [$clog2(NUM_CODES)+lzwc_pkg::BYTE_W-1:0]  waddr,
  input  logic [$clog2(NUM_CODES)-1:0]                   wdata,
  input  logic                                           re,
  input  logic [$clog2(NUM_CODES)+lzwc_pkg::BYTE_W-1:0]  raddr,
  output logic [$clog2(NUM_CODES)-1:0]                   rdata
);
  import lzwc_pkg::*;

  localparam int CODE_W = $clog2(NUM_CODES);
  localparam int DEPTH = NUM_CODES * (1 << BYTE_W);

  logic [CODE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/lzwc_out_fifo.sv
`timescale 1ns / 1ps

// Small result queue between the sequencer and the output channel.
module lzwc_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  lzwc_pkg::res_t                 push_data,
  output logic [lzwc_pkg::OUT_CNT_W-1:0] count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lzwc_pkg::res_t                 head
);
  import lzwc_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);

  res_t             slots [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             pop;

  assign out_valid = (count != '0);
  assign pop = out_valid && out_ready;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + OUT_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - OUT_CNT_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/lzw_trie_compressor.sv
`timescale 1ns / 1ps

// LZW compressor with a direct-indexed dictionary. Each input beat carries one
// byte and a flag that marks the last byte of a stream; each output beat carries
// one code, a flag on the last result of that input beat, and a flag on the code
// that flushes the stream. The dictionary lives in one synchronous RAM of
// NUM_CODES*256 entries indexed by (prefix code, byte). For each byte, the
// accept cycle issues the RAM read and the next cycle acts on the read data,
// writing a new entry on a miss. A final byte that misses also takes a flush beat.
// When the dictionary is full, the block emits the reset marker 0 and then (after
// any flush) runs a clearing pass over all NUM_CODES*256 entries (1048576 at the
// default size) during which no byte is taken; the same pass runs after reset
// before the first byte is accepted. Input is also held off while the result
// queue lacks room for the three results a byte can cause.
module lzw_trie_compressor #(
  parameter int NUM_CODES = lzwc_pkg::NUM_CODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lzwc_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          final_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lzwc_pkg::CW_W-1:0]     code_word,
  output logic                          last_of_run,
  output logic                          end_of_stream
);
  import lzwc_pkg::*;

  localparam int CODE_W = $clog2(NUM_CODES);
  localparam int ADDR_W = CODE_W + BYTE_W;
  localparam int DEPTH = NUM_CODES * (1 << BYTE_W);
  localparam int NF_W = CODE_W + 1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_MARK  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [CODE_W-1:0]   prefix, prefix_next;
  logic [NF_W-1:0]     next_free, next_free_next;
  logic [BYTE_W-1:0]   byte_q, byte_q_next;
  logic                fin_q, fin_q_next;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic                clr_pending, clr_pending_next;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CODE_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [CODE_W-1:0]   mem_rdata;

  logic                push;
  res_t                push_data;
  res_t                head;
  logic [OUT_CNT_W-1:0] fifo_count;

  logic                accept;
  logic [CODE_W-1:0]   root;
  logic [CODE_W-1:0]   child;
  logic                hit;
  logic                full;

  lzwc_child_mem #(
    .NUM_CODES (NUM_CODES)
  ) u_child_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lzwc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .count     (fifo_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign code_word = head.code;
  assign last_of_run = head.last;
  assign end_of_stream = head.eos;

  // A new byte needs the dictionary idle and room for its worst-case results.
  assign in_ready = (state == ST_IDLE) && (fifo_count <= OUT_CNT_W'(OUT_DEPTH - MAX_RES));
  assign accept = in_valid && in_ready;

  // The read for a byte is issued on its accept edge; the data is used in ST_LOOK.
  // Writes happen only in ST_LOOK and ST_CLEAR, so a read never meets a write
  // to the same entry in the same cycle.
  assign mem_re = accept;
  assign mem_raddr = {prefix, data_byte};

  // The root row is fixed (byte b maps to code b+1), so it is produced here and
  // the RAM row for code 0 is never consulted.
  assign root = CODE_W'(byte_q) + CODE_W'(1);
  assign child = (prefix == '0) ? root : mem_rdata;
  assign hit = (child != '0);
  assign full = (next_free == NF_W'(NUM_CODES));

  always_comb begin
    state_next = state;
    prefix_next = prefix;
    next_free_next = next_free;
    byte_q_next = byte_q;
    fin_q_next = fin_q;
    clr_addr_next = clr_addr;
    clr_pending_next = clr_pending;
    mem_we = 1'b0;
    mem_waddr = {prefix, byte_q};
    mem_wdata = next_free[CODE_W-1:0];
    push = 1'b0;
    push_data = '{code: CW_W'(prefix), last: 1'b0, eos: 1'b0};

    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          clr_addr_next = '0;
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          byte_q_next = data_byte;
          fin_q_next = final_byte;
          state_next = ST_LOOK;
        end
      end

      ST_LOOK: begin
        if (hit) begin
          if (fin_q) begin
            push = 1'b1;
            push_data = '{code: CW_W'(child), last: 1'b1, eos: 1'b1};
            prefix_next = '0;
          end else begin
            prefix_next = child;
          end
          state_next = ST_IDLE;
        end else begin
          push = 1'b1;
          push_data = '{code: CW_W'(prefix), last: !full && !fin_q, eos: 1'b0};
          prefix_next = root;
          if (full) begin
            state_next = ST_MARK;
          end else begin
            mem_we = 1'b1;
            next_free_next = next_free + NF_W'(1);
            state_next = fin_q ? ST_FLUSH : ST_IDLE;
          end
        end
      end

      ST_MARK: begin
        // Reset marker; the clearing pass follows, after the flush if any.
        // The pending flag only carries the pass across the flush beat.
        push = 1'b1;
        push_data = '{code: '0, last: !fin_q, eos: 1'b0};
        next_free_next = NF_W'(FIRST_FREE);
        clr_pending_next = fin_q;
        state_next = fin_q ? ST_FLUSH : ST_CLEAR;
      end

      ST_FLUSH: begin
        push = 1'b1;
        push_data = '{code: CW_W'(prefix), last: 1'b1, eos: 1'b1};
        prefix_next = '0;
        clr_pending_next = 1'b0;
        state_next = clr_pending ? ST_CLEAR : ST_IDLE;
      end

      default: begin
        state_next = ST_CLEAR;
        clr_addr_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      prefix <= '0;
      next_free <= NF_W'(FIRST_FREE);
      clr_addr <= '0;
      clr_pending <= 1'b0;
    end else begin
      state <= state_next;
      prefix <= prefix_next;
      next_free <= next_free_next;
      clr_addr <= clr_addr_next;
      clr_pending <= clr_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    byte_q <= byte_q_next;
    fin_q <= fin_q_next;
  end

`ifndef SYNTHESIS
  a_next_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= NF_W'(NUM_CODES))
    else $error("next free code ran past the dictionary size");

  a_root_row_untouched: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == ST_LOOK)) |-> (mem_waddr[ADDR_W-1:BYTE_W] != '0))
    else $error("dictionary write into the root row");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ((fifo_count < OUT_CNT_W'(OUT_DEPTH)) || (out_valid && out_ready)))
    else $error("result queue overflow");

  a_marker_resets_codes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK) |=> (next_free == NF_W'(FIRST_FREE)))
    else $error("next free code not restored after the reset marker");

  a_eos_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_stream) |-> last_of_run)
    else $error("stream flush beat not marked as last of its run");
`endif

endmodule
